@@ rtl/ssd_pkg.sv @@
// shared constants, codes and segment table for the seven-segment scan driver
`timescale 1ns / 1ps

package ssd_pkg;

	localparam int NUM_DIGITS_DEF = 4;
	localparam int ENABLE_W       = 4;

	// request kinds on the input side
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result kinds on the output side
	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_SCAN = 1'b1;

	// command bytes
	localparam logic [7:0] CMD_SHOW = 8'h77;
	localparam logic [7:0] CMD_HOME = 8'h66;
	localparam logic [7:0] CODE_MAX = 8'h0d;

	localparam logic [7:0] DP_BIT   = 8'h80;
	localparam int         DP_DIGIT = 2;

	// segment pattern for a stored digit code
	function automatic logic [7:0] seg_lookup(input logic [3:0] code);
		logic [7:0] seg;
		case (code)
			4'd0:    seg = 8'h3f;
			4'd1:    seg = 8'h06;
			4'd2:    seg = 8'h5b;
			4'd3:    seg = 8'h4f;
			4'd4:    seg = 8'h66;
			4'd5:    seg = 8'h6d;
			4'd6:    seg = 8'h7d;
			4'd7:    seg = 8'h07;
			4'd8:    seg = 8'h7f;
			4'd9:    seg = 8'h6f;
			4'd10:   seg = 8'h40;        // dash
			4'd11:   seg = 8'h00;        // blank
			4'd12:   seg = 8'b01111001;  // 'E'
			4'd13:   seg = 8'b01010000;  // 'r'
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

@@ rtl/seven_segment_scan_driver.sv @@
// multiplexed seven-segment scan driver: command bytes, scan ticks, digit stores
`timescale 1ns / 1ps
// path: an accepted request is held in the input register, then moves into the
//   result register, where it waits while the receiver stalls
// throughput: one request per cycle; a request is still taken into the input
//   register while a finished result waits, stall only when both are full
// reset: clears both digit stores, write and scan positions, segment latch
//   and all valid flags; payload registers are not reset

module seven_segment_scan_driver #(
	parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// request side
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] rx_byte,
	input  logic       blank_pin,
	// result side
	output logic       out_valid,
	input  logic       out_stall,
	output logic       item_kind,
	output logic [7:0] echo_byte,
	output logic [7:0] segment_bits,
	output logic [ssd_pkg::ENABLE_W-1:0] digit_enable
);

	localparam int PosW = $clog2(NUM_DIGITS);
	localparam int EnW  = ssd_pkg::ENABLE_W;

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] rx_s1;
	logic       blank_s1;

	// block state
	logic [3:0]      pending_q [NUM_DIGITS];
	logic [3:0]      shown_q   [NUM_DIGITS];
	logic [PosW-1:0] wp_q;
	logic [PosW-1:0] scan_q;
	logic [7:0]      seg_latch_q;

	// result register
	logic           out_valid_q;
	logic           kind_q;
	logic [7:0]     echo_q;
	logic [7:0]     seg_q;
	logic [EnW-1:0] en_q;

	// handshake
	logic out_blocked;
	logic advance;

	// next-state and result logic
	logic            is_show;
	logic            is_home;
	logic            is_code;
	logic            is_scan;
	logic [PosW-1:0] wp_next;
	logic [PosW-1:0] scan_next;
	logic [EnW-1:0]  scan_ext;
	logic [7:0]      seg_scan;
	logic [7:0]      seg_d;
	logic [EnW-1:0]  en_d;

	assign out_blocked = out_valid_q && out_stall;
	assign advance     = valid_s1 && !out_blocked;
	// input register may refill as it drains, so stall only when it cannot move
	assign in_stall    = valid_s1 && out_blocked;

	// command decode
	assign is_show = (op_s1 == ssd_pkg::OP_BYTE) && (rx_s1 == ssd_pkg::CMD_SHOW);
	assign is_home = (op_s1 == ssd_pkg::OP_BYTE) && (rx_s1 == ssd_pkg::CMD_HOME);
	assign is_code = (op_s1 == ssd_pkg::OP_BYTE) && (rx_s1 <= ssd_pkg::CODE_MAX);
	// a tick with the blank pin low drives a digit
	assign is_scan = (op_s1 == ssd_pkg::OP_TICK) && !blank_s1;

	// positions wrap at the digit count, which need not be a power of two
	assign wp_next   = (wp_q == PosW'(NUM_DIGITS - 1)) ? '0 : wp_q + PosW'(1);
	assign scan_next = (scan_q == PosW'(NUM_DIGITS - 1)) ? '0 : scan_q + PosW'(1);

	assign scan_ext = EnW'(scan_q);

	always_comb begin
		seg_scan = ssd_pkg::seg_lookup(shown_q[scan_q]);
		// decimal point only on its own digit
		if (scan_ext == EnW'(ssd_pkg::DP_DIGIT)) begin
			seg_scan = seg_scan | ssd_pkg::DP_BIT;
		end
	end

	// the latch is held on echoes and blanked ticks
	assign seg_d = is_scan ? seg_scan : seg_latch_q;

	// one-hot enable, digits beyond the enable width stay dark
	always_comb begin
		for (int i = 0; i < EnW; i++) begin
			en_d[i] = is_scan && (i < NUM_DIGITS) && (scan_ext == EnW'(i));
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= op;
			rx_s1    <= rx_byte;
			blank_s1 <= blank_pin;
		end
	end

	// digit stores, positions and segment latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				pending_q[i] <= '0;
				shown_q[i]   <= '0;
			end
			wp_q        <= '0;
			scan_q      <= '0;
			seg_latch_q <= '0;
		end else if (advance) begin
			if (is_show) begin
				// copy pending codes into the display store
				for (int i = 0; i < NUM_DIGITS; i++) begin
					shown_q[i] <= pending_q[i];
				end
			end else if (is_home) begin
				wp_q <= '0;
			end else if (is_code) begin
				pending_q[wp_q] <= rx_s1[3:0];
				wp_q            <= wp_next;
			end
			if (is_scan) begin
				seg_latch_q <= seg_scan;
				scan_q      <= scan_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_blocked) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= (op_s1 == ssd_pkg::OP_TICK) ? ssd_pkg::KIND_SCAN : ssd_pkg::KIND_ECHO;
			echo_q <= (op_s1 == ssd_pkg::OP_BYTE) ? rx_s1 : 8'h00;
			seg_q  <= seg_d;
			en_q   <= en_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign item_kind    = kind_q;
	assign echo_byte    = echo_q;
	assign segment_bits = seg_q;
	assign digit_enable = en_q;

	// echoes never light a digit
	a_echo_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == ssd_pkg::KIND_ECHO) |-> (en_q == '0))
		else $error("digit enable set on an echo result");

	// at most one digit lit
	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0(en_q))
		else $error("more than one digit enable set");

	// scan results carry no echo byte
	a_scan_no_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == ssd_pkg::KIND_SCAN) |-> (echo_q == 8'h00))
		else $error("echo byte set on a scan result");

	// a driven digit has the decimal point exactly when it is the point digit
	a_dp_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (en_q != '0) |-> (seg_q[7] == en_q[ssd_pkg::DP_DIGIT]))
		else $error("decimal point on the wrong digit");

	// input register holds while stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("input register lost a request under stall");

endmodule

@@ dv/seven_segment_scan_driver_test.sv @@
// testbench for the seven-segment scan driver: directed and random requests
`timescale 1ns / 1ps

module seven_segment_scan_driver_test;
	import ssd_pkg::*;

	localparam int DIGITS      = NUM_DIGITS_DEF;
	localparam int QUIET_LIMIT = 3000;  // cycles with nothing accepted on either side
	localparam int HOLD_CYCLES = 160;   // long receiver hold-off
	localparam int SETTLE      = 5;     // time through the input and result registers plus margin

	// segment patterns for codes 15 down to 0 (14 and 15 are never stored)
	localparam logic [16*8-1:0] GLYPHS = {
		8'h00, 8'h00, 8'h50, 8'h79, 8'h00, 8'h40, 8'h6f, 8'h7f,
		8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
	};

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
		logic       blank_pin;
	} request_t;

	typedef struct packed {
		logic                item_kind;
		logic [7:0]          echo_byte;
		logic [7:0]          segment_bits;
		logic [ENABLE_W-1:0] digit_enable;
	} display_out_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic                op        = OP_BYTE;
	logic [7:0]          rx_byte   = 8'h00;
	logic                blank_pin = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                item_kind;
	logic [7:0]          echo_byte;
	logic [7:0]          segment_bits;
	logic [ENABLE_W-1:0] digit_enable;

	// idling controls; a test that does not set them keeps the last values
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// hold-off handshake between the tests and the receiver process
	int hold_asked   = 0;
	int hold_granted = 0;
	int hold_left    = 0;

	int mismatches   = 0;
	int quiet_cycles = 0;

	// predicted display state
	logic [3:0] pend_codes [DIGITS];
	logic [3:0] lit_codes [DIGITS];
	int         write_pos;
	int         scan_pos;
	logic [7:0] seg_hold;

	display_out_t display_due [$];
	display_out_t want;

	seven_segment_scan_driver #(
		.NUM_DIGITS(DIGITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.rx_byte     (rx_byte),
		.blank_pin   (blank_pin),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.item_kind   (item_kind),
		.echo_byte   (echo_byte),
		.segment_bits(segment_bits),
		.digit_enable(digit_enable)
	);

	// 12 ns clock, low half first so there is no edge at time zero
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// predicted state straight out of reset
	function automatic void clear_display();
		int i;
		for (i = 0; i < DIGITS; i++) begin
			pend_codes[i] = 4'd0;
			lit_codes[i]  = 4'd0;
		end
		write_pos = 0;
		scan_pos  = 0;
		seg_hold  = 8'h00;
	endfunction

	// apply one request to the predicted state and return the result it causes
	function automatic display_out_t advance_display(request_t req);
		display_out_t res;
		logic [7:0]   glyph;
		int           i;
		res = '0;
		if (req.op == OP_BYTE) begin
			if (req.rx_byte == CMD_SHOW) begin
				// latch the pending codes into the visible store
				for (i = 0; i < DIGITS; i++)
					lit_codes[i] = pend_codes[i];
			end else if (req.rx_byte == CMD_HOME) begin
				write_pos = 0;
			end else if (req.rx_byte <= CODE_MAX) begin
				pend_codes[write_pos] = req.rx_byte[3:0];
				write_pos = (write_pos + 1) % DIGITS;
			end
			// anything else is only echoed
			res.item_kind    = KIND_ECHO;
			res.echo_byte    = req.rx_byte;
			res.segment_bits = seg_hold;
			res.digit_enable = '0;
		end else begin
			res.item_kind = KIND_SCAN;
			res.echo_byte = 8'h00;
			if (req.blank_pin == 1'b0) begin
				glyph = GLYPHS[int'(lit_codes[scan_pos]) * 8 +: 8];
				if (scan_pos == DP_DIGIT)
					glyph = glyph | DP_BIT;
				seg_hold = glyph;
				// digits past the enable width get no enable bit
				res.digit_enable = (scan_pos < ENABLE_W) ? ENABLE_W'(1) << scan_pos : '0;
				scan_pos = (scan_pos + 1) % DIGITS;
			end
			// a blanked tick holds the latch and the scan position
			res.segment_bits = seg_hold;
		end
		return res;
	endfunction

	// offer one request, with random idle cycles ahead of it, and log its result once taken
	task automatic send_request(input logic op_v, input logic [7:0] byte_v, input logic blank_v);
		request_t req;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		req       = '{op: op_v, rx_byte: byte_v, blank_pin: blank_v};
		in_valid  <= 1'b1;
		op        <= op_v;
		rx_byte   <= byte_v;
		blank_pin <= blank_v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		display_due.push_back(advance_display(req));
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (display_due.size() != 0);
	endtask

	// scan the all-zero store straight after reset, then one blanked tick
	task automatic test_after_reset();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (DIGITS)
			send_request(OP_TICK, 8'h00, 1'b0);
		send_request(OP_TICK, 8'h00, 1'b1);
		wait_for_drain();
	endtask

	// letters, dash and blank written, shown and scanned; dash lands on the decimal point digit
	task automatic test_glyph_codes();
		send_request(OP_BYTE, CODE_MAX, 1'b1);
		send_request(OP_BYTE, 8'h0c, 1'b0);
		send_request(OP_BYTE, 8'h0a, 1'b1);
		send_request(OP_BYTE, 8'h0b, 1'b0);
		send_request(OP_BYTE, CMD_SHOW, 1'b0);
		repeat (DIGITS)
			send_request(OP_TICK, 8'hff, 1'b0);
		wait_for_drain();
	endtask

	// bytes outside the code range, write position home, blanked tick with a busy byte field
	task automatic test_commands();
		send_request(OP_BYTE, 8'hff, 1'b0);
		send_request(OP_BYTE, CODE_MAX + 8'd1, 1'b1);
		send_request(OP_BYTE, 8'h80, 1'b0);
		send_request(OP_BYTE, CMD_HOME, 1'b0);
		send_request(OP_BYTE, 8'h09, 1'b0);
		send_request(OP_BYTE, CMD_SHOW, 1'b1);
		send_request(OP_TICK, 8'hff, 1'b1);
		send_request(OP_TICK, 8'h5a, 1'b0);
		send_request(OP_TICK, 8'ha5, 1'b0);
		wait_for_drain();
	endtask

	// the receiver holds off for a long stretch while requests keep coming, so the input stalls
	task automatic test_back_pressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_asked <= hold_asked + 1;
		repeat (12) begin
			if ($urandom_range(1))
				send_request(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
			else
				send_request(OP_BYTE, 8'($urandom_range(CODE_MAX)), 1'($urandom_range(1)));
		end
		wait_for_drain();
	endtask

	// mostly complete frames (home, codes, show, a run of ticks) mixed with loose ticks and bytes
	task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
			input int quota);
		int sent;
		int pick;
		int runs;
		send_idle_pct  = sender_idle;
		recv_stall_pct = receiver_stall;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				if ($urandom_range(3) != 0) begin
					send_request(OP_BYTE, CMD_HOME, 1'($urandom_range(1)));
					sent++;
				end
				runs = $urandom_range(6, 1);
				repeat (runs) begin
					send_request(OP_BYTE, 8'($urandom_range(CODE_MAX)),
						1'($urandom_range(1)));
					sent++;
				end
				send_request(OP_BYTE, CMD_SHOW, 1'($urandom_range(1)));
				sent++;
				runs = $urandom_range(10, 1);
				repeat (runs) begin
					send_request(OP_TICK, 8'($urandom_range(255)), $urandom_range(99) < 15);
					sent++;
				end
			end else if (pick < 85) begin
				send_request(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
				sent++;
			end else begin
				// any byte at all, commands and codes included
				send_request(OP_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
				sent++;
			end
		end
		wait_for_drain();
	endtask

	// receiver: random stalls, or a counted hold-off when a test asks for one
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_granted) begin
			hold_granted <= hold_asked;
			hold_left    <= HOLD_CYCLES;
			out_stall    <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic void compare_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %02h, got %02h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// every accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (display_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got kind %0d echo %02h",
					$time, item_kind, echo_byte);
				$display("%0t: unexpected result seg %02h en %h",
					$time, segment_bits, digit_enable);
				mismatches++;
			end else begin
				want = display_due.pop_front();
				compare_field("item_kind", 8'(want.item_kind), 8'(item_kind));
				compare_field("echo_byte", want.echo_byte, echo_byte);
				compare_field("segment_bits", want.segment_bits, segment_bits);
				compare_field("digit_enable", 8'(want.digit_enable), 8'(digit_enable));
			end
		end
	end

	// watchdog: too long with nothing accepted on either side means a hang
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		clear_display();
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_glyph_codes();
		test_commands();
		test_back_pressure();
		// sender busy and receiver mostly stalled, then the other way round, then flat out
		test_random_traffic(21, 82, 600);
		test_random_traffic(82, 21, 600);
		test_random_traffic(0, 0, 600);

		repeat (SETTLE)
			@(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
rtl/ssd_pkg.sv
rtl/seven_segment_scan_driver.sv
dv/seven_segment_scan_driver_test.sv
